// ===== sv/qsp_pkg.sv =====
// Package for the QR split plan search: payload types, status codes,
// register indexes and the level-L alphanumeric capacity table.
// No dependencies.
`default_nettype none

package qsp_pkg;

  localparam int unsigned LEN_W     = 23;
  localparam int unsigned PARTS_W   = 11;
  localparam int unsigned VER_W     = 6;
  localparam int unsigned PER_W     = 13;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 11;

  // divider: dividend is len + adj - 1, one bit wider than len
  localparam int unsigned DVD_W  = LEN_W + 1;
  localparam int unsigned DCNT_W = $clog2(DVD_W + 1);

  localparam logic [VER_W-1:0]   VERSION_LIMIT = VER_W'(40);
  localparam logic [PARTS_W-1:0] PART_LIMIT    = PARTS_W'(1295);
  localparam logic [PER_W-1:0]   HDR_CHARS     = PER_W'(8);

  localparam logic [CFG_IDX_W-1:0] REG_MIN_PARTS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PARTS = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_MIN_VER   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_VER   = CFG_IDX_W'(3);

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_VER   = 2'd1,
    ST_BAD_SPLIT = 2'd2,
    ST_NO_FIT    = 2'd3
  } qsp_status_e;

  typedef struct packed {
    logic [LEN_W-1:0] payload_length;
    logic             hex_encoding;
  } qsp_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [PARTS_W-1:0] part_count;
    logic [VER_W-1:0]   qr_version;
    logic [PER_W-1:0]   chars_per_part;
  } qsp_out_t;

  typedef struct packed {
    logic [PARTS_W-1:0] min_parts;
    logic [PARTS_W-1:0] max_parts;
    logic [VER_W-1:0]   min_qr_version;
    logic [VER_W-1:0]   max_qr_version;
  } qsp_cfg_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [PER_W-1:0] divisor;
  } qsp_div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } qsp_div_rsp_t;

  // alphanumeric capacity at error level L, versions 1..40
  function automatic logic [PER_W-1:0] cap_lookup(input logic [VER_W-1:0] ver);
    logic [PER_W-1:0] c;
    case (ver)
      6'd1:  c = 13'd25;    6'd2:  c = 13'd47;    6'd3:  c = 13'd77;
      6'd4:  c = 13'd114;   6'd5:  c = 13'd154;   6'd6:  c = 13'd195;
      6'd7:  c = 13'd224;   6'd8:  c = 13'd279;   6'd9:  c = 13'd335;
      6'd10: c = 13'd395;   6'd11: c = 13'd468;   6'd12: c = 13'd535;
      6'd13: c = 13'd619;   6'd14: c = 13'd667;   6'd15: c = 13'd758;
      6'd16: c = 13'd854;   6'd17: c = 13'd938;   6'd18: c = 13'd1046;
      6'd19: c = 13'd1153;  6'd20: c = 13'd1249;  6'd21: c = 13'd1352;
      6'd22: c = 13'd1460;  6'd23: c = 13'd1588;  6'd24: c = 13'd1704;
      6'd25: c = 13'd1853;  6'd26: c = 13'd1990;  6'd27: c = 13'd2132;
      6'd28: c = 13'd2223;  6'd29: c = 13'd2369;  6'd30: c = 13'd2520;
      6'd31: c = 13'd2677;  6'd32: c = 13'd2840;  6'd33: c = 13'd3009;
      6'd34: c = 13'd3183;  6'd35: c = 13'd3351;  6'd36: c = 13'd3537;
      6'd37: c = 13'd3729;  6'd38: c = 13'd3927;  6'd39: c = 13'd4087;
      6'd40: c = 13'd4296;
      default: c = 13'd25;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== sv/qsp_div.sv =====
// Restoring divider, one quotient bit per cycle, for the split plan search.
// Depends on qsp_pkg.
`default_nettype none

module qsp_div
  import qsp_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire qsp_div_req_t req_i,
  output qsp_div_rsp_t      rsp_o
);

  logic [DVD_W-1:0]  acc_q;   // dividend bits out, quotient bits in
  logic [PER_W-1:0]  rem_q;
  logic [PER_W-1:0]  dsr_q;
  logic [DCNT_W-1:0] cnt_q;
  logic              busy_q;
  logic              done_q;

  logic [PER_W:0] r_sh;
  logic           ge;
  logic [PER_W:0] diff;

  assign r_sh = {rem_q, acc_q[DVD_W-1]};
  assign ge   = (r_sh >= {1'b0, dsr_q});
  assign diff = r_sh - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      rem_q  <= '0;
      dsr_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (req_i.start) begin
      acc_q  <= req_i.dividend;
      rem_q  <= '0;
      dsr_q  <= req_i.divisor;
      cnt_q  <= DCNT_W'(DVD_W);
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      acc_q <= {acc_q[DVD_W-2:0], ge};
      rem_q <= ge ? diff[PER_W-1:0] : r_sh[PER_W-1:0];
      cnt_q <= cnt_q - DCNT_W'(1);
      if (cnt_q == DCNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = acc_q;

endmodule

`default_nettype wire

// ===== sv/qsp_cfg_regs.sv =====
// Configuration registers of the split plan search: part and version limits.
// Depends on qsp_pkg.
`default_nettype none

module qsp_cfg_regs
  import qsp_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_DAT_W-1:0] cfg_data_i,
  output qsp_cfg_t                  cfg_o
);

  qsp_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_parts      <= PARTS_W'(1);
      cfg_q.max_parts      <= PART_LIMIT;
      cfg_q.min_qr_version <= VER_W'(1);
      cfg_q.max_qr_version <= VERSION_LIMIT;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MIN_PARTS: cfg_q.min_parts      <= cfg_data_i[PARTS_W-1:0];
        REG_MAX_PARTS: cfg_q.max_parts      <= cfg_data_i[PARTS_W-1:0];
        REG_MIN_VER:   cfg_q.min_qr_version <= cfg_data_i[VER_W-1:0];
        REG_MAX_VER:   cfg_q.max_qr_version <= cfg_data_i[VER_W-1:0];
        default:       cfg_q <= cfg_q;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== sv/qr_split_plan_search_core.sv =====
// QR split plan search, top level: sequencer over the version range.
// A range error goes from the idle state straight to the finish state; otherwise
// the sequencer walks N versions (N = versions in range, at most 40). Each version
// passes through the table/setup state and the divide state (24 quotient bits, then hand-back).
// One transaction at a time: in_stall_o is high from acceptance until the result
// moves into the output register, so a new one is not taken before the last one
// is through. Reset (async, active low) restores defaults.
// Depends on qsp_pkg, qsp_cfg_regs, qsp_div.
`default_nettype none

module qr_split_plan_search_core
  import qsp_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration write port
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_DAT_W-1:0] cfg_data_i,
  // input channel
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire qsp_in_t              in_data_i,
  // result channel
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output qsp_out_t                  out_data_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_DIV,
    S_FINISH
  } state_e;

  state_e             state_q;
  qsp_cfg_t           cfg;
  qsp_div_req_t       div_req;
  qsp_div_rsp_t       div_rsp;

  logic [LEN_W-1:0]   len_q;
  logic               hex_q;
  logic [VER_W-1:0]   ver_q;
  logic [PER_W-1:0]   adj_q;
  logic               found_q;
  logic [PARTS_W-1:0] best_cnt_q;
  logic [VER_W-1:0]   best_ver_q;
  logic [PER_W-1:0]   best_per_q;
  qsp_status_e        status_q;
  logic               out_valid_q;
  qsp_out_t           out_q;

  qsp_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  qsp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // range checks: version range first, split range second
  logic ver_bad, split_bad;
  assign ver_bad = (cfg.min_qr_version > cfg.max_qr_version) ||
                   (cfg.min_qr_version == '0) ||
                   (cfg.max_qr_version > VERSION_LIMIT);
  assign split_bad = (cfg.min_parts > cfg.max_parts) ||
                     (cfg.min_parts == '0) ||
                     (cfg.max_parts > PART_LIMIT);

  logic in_acc;
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  // usable capacity of the current version, rounded down to the granule
  logic [PER_W-1:0] base, adj;
  assign base = cap_lookup(ver_q) - HDR_CHARS;
  assign adj  = hex_q ? {base[PER_W-1:1], 1'b0} : {base[PER_W-1:3], 3'b000};

  // divider start: ceil(len / adj) as (len + adj - 1) / adj
  assign div_req.start    = (state_q == S_LOAD);
  assign div_req.dividend = {1'b0, len_q} + {{(DVD_W-PER_W){1'b0}}, adj} - DVD_W'(1);
  assign div_req.divisor  = adj;

  // candidate evaluation; the part count is always the ceiling quotient
  logic [DVD_W-1:0] q;
  logic             in_range, better;
  logic [PER_W-1:0] per;
  assign q        = div_rsp.quotient;
  assign in_range = (q >= {{(DVD_W-PARTS_W){1'b0}}, cfg.min_parts}) &&
                    (q <= {{(DVD_W-PARTS_W){1'b0}}, cfg.max_parts});
  assign better   = !found_q || (q[PARTS_W-1:0] < best_cnt_q);
  // a single part carries the whole payload, which then fits in PER_W bits
  assign per      = (q == DVD_W'(1)) ? len_q[PER_W-1:0] : adj_q;

  logic out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      hex_q       <= 1'b0;
      ver_q       <= '0;
      adj_q       <= '0;
      found_q     <= 1'b0;
      best_cnt_q  <= '0;
      best_ver_q  <= '0;
      best_per_q  <= '0;
      status_q    <= ST_OK;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      // the finish state refills the output register itself
      if (out_valid_q && !out_stall_i && state_q != S_FINISH) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            len_q      <= in_data_i.payload_length;
            hex_q      <= in_data_i.hex_encoding;
            ver_q      <= cfg.min_qr_version;
            found_q    <= 1'b0;
            best_cnt_q <= '0;
            best_ver_q <= '0;
            best_per_q <= '0;
            if (ver_bad) begin
              status_q <= ST_BAD_VER;
              state_q  <= S_FINISH;
            end else if (split_bad) begin
              status_q <= ST_BAD_SPLIT;
              state_q  <= S_FINISH;
            end else begin
              status_q <= ST_OK;
              state_q  <= S_LOAD;
            end
          end
        end
        S_LOAD: begin
          adj_q   <= adj;
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            if (in_range && better) begin
              found_q    <= 1'b1;
              best_cnt_q <= q[PARTS_W-1:0];
              best_ver_q <= ver_q;
              best_per_q <= per;
            end
            if (ver_q == cfg.max_qr_version) begin
              // a candidate found on this very cycle still counts
              if (!found_q && !in_range) begin
                status_q <= ST_NO_FIT;
              end
              state_q <= S_FINISH;
            end else begin
              ver_q   <= ver_q + VER_W'(1);
              state_q <= S_LOAD;
            end
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_q.status <= status_q;
            if (status_q == ST_OK) begin
              out_q.part_count     <= best_cnt_q;
              out_q.qr_version     <= best_ver_q;
              out_q.chars_per_part <= best_per_q;
            end else begin
              out_q.part_count     <= '0;
              out_q.qr_version     <= '0;
              out_q.chars_per_part <= '0;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
